[src/lcar_pkg.sv]
// Shared types, constants and codes of the loop current average and report block.
package lcar_pkg;

    localparam int SAMPLES_PER_GROUP = 8;
    localparam int SAMPLE_BITS       = 10;
    localparam int GROUP_SHIFT       = $clog2(SAMPLES_PER_GROUP);
    localparam int SUM_BITS          = SAMPLE_BITS + GROUP_SHIFT;
    localparam int COUNT_BITS        = $clog2(SAMPLES_PER_GROUP + 1);

    localparam int ADC_BITS       = 10;
    localparam int DEADBAND_BITS  = 10;
    localparam int SECONDS_BITS   = 16;
    localparam int STATUS_BITS    = 2;
    localparam int VALUE_BITS     = 8;
    localparam int AVG_BITS       = 10;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam int PROD_BITS    = ADC_BITS + VALUE_BITS;
    localparam int DIV_CNT_BITS = $clog2(VALUE_BITS);

    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    localparam logic [VALUE_BITS-1:0] VALUE_INVALID = 8'd255;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic [STATUS_BITS-1:0] STATUS_INTERVAL  = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_DEADBAND  = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_UNCHANGED = 2'd2;
    localparam logic [STATUS_BITS-1:0] STATUS_SENT      = 2'd3;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_ADC_MIN       = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ADC_MAX       = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEADBAND      = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SEND_INTERVAL = 2'd3;

    localparam logic [ADC_BITS-1:0]      ADC_MIN_RESET       = 10'd87;
    localparam logic [ADC_BITS-1:0]      ADC_MAX_RESET       = 10'd962;
    localparam logic [DEADBAND_BITS-1:0] DEADBAND_RESET      = 10'd3;
    localparam logic [SECONDS_BITS-1:0]  SEND_INTERVAL_RESET = 16'd60;

    typedef struct packed {
        logic [ADC_BITS-1:0]      adc_min;
        logic [ADC_BITS-1:0]      adc_max;
        logic [DEADBAND_BITS-1:0] deadband;
        logic [SECONDS_BITS-1:0]  send_interval;
    } cfg_t;

    typedef struct packed {
        logic                   is_tick;
        logic                   inv;
        logic [SAMPLE_BITS-1:0] avg;
    } job_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [VALUE_BITS-1:0]  out_value;
        logic [AVG_BITS-1:0]    raw_average;
        logic                   invalid;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_DECIDE
    } back_state_t;

endpackage

[src/lcar_front.sv]
// Front end: accepts samples and ticks, sums groups and emits group-end and tick jobs.
module lcar_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  lcar_pkg::cfg_t                     cfg,
    input  logic                               push,
    input  logic                               operation,
    input  logic [lcar_pkg::SAMPLE_BITS-1:0]   sample,
    input  logic                               q_full,
    output logic                               enq_valid,
    output lcar_pkg::job_t                     enq_job
);
    import lcar_pkg::*;

    localparam logic [COUNT_BITS-1:0] LAST_COUNT = COUNT_BITS'(SAMPLES_PER_GROUP - 1);

    logic [SUM_BITS-1:0]   sum_reg;
    logic [SUM_BITS-1:0]   sum_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [SUM_BITS-1:0]   sum_add;
    logic                  is_tick;
    logic                  in_range;
    logic                  last;
    logic                  accept;

    always_comb
    begin
        is_tick  = (operation == OP_TICK);
        in_range = (sample >= cfg.adc_min) && (sample <= cfg.adc_max);
        sum_add  = sum_reg + SUM_BITS'(sample);
        last     = (count_reg == LAST_COUNT);
        accept   = push && !q_full;

        enq_valid       = accept && (is_tick || !in_range || last);
        enq_job.is_tick = is_tick;
        enq_job.inv     = !is_tick && !in_range;
        enq_job.avg     = (is_tick || !in_range) ? '0 : SAMPLE_BITS'(sum_add >> GROUP_SHIFT);

        sum_next   = sum_reg;
        count_next = count_reg;
        if (accept && !is_tick)
        begin
            if (!in_range || last)
            begin
                sum_next   = '0;
                count_next = '0;
            end
            else
            begin
                sum_next   = sum_add;
                count_next = count_reg + COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

endmodule

[src/lcar_queue.sv]
// Short job queue between the front end and the back end.
module lcar_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    input  lcar_pkg::job_t wr_job,
    output logic           full,
    input  logic           rd_pop,
    output logic           rd_valid,
    output lcar_pkg::job_t rd_job
);
    import lcar_pkg::*;

    job_t                      entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_next;
    logic [QUEUE_CNT_BITS-1:0] count_reg;
    logic [QUEUE_CNT_BITS-1:0] count_next;
    logic                      do_wr;
    logic                      do_rd;

    always_comb
    begin
        full     = (count_reg == QUEUE_CNT_BITS'(QUEUE_DEPTH));
        rd_valid = (count_reg != '0);
        rd_job   = entry_reg[rd_ptr_reg];
        do_wr    = wr_valid && !full;
        do_rd    = rd_pop && rd_valid;

        wr_ptr_next = do_wr ? wr_ptr_reg + QUEUE_PTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + QUEUE_PTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + QUEUE_CNT_BITS'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - QUEUE_CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[src/lcar_back.sv]
// Back end: seconds counter, iterative scaling divide, send decision and result register.
module lcar_back (
    input  logic              clk,
    input  logic              rst_n,
    input  lcar_pkg::cfg_t    cfg,
    input  logic              q_valid,
    input  lcar_pkg::job_t    q_job,
    output logic              q_pop,
    input  logic              pop,
    output logic              out_valid,
    output lcar_pkg::result_t result
);
    import lcar_pkg::*;

    back_state_t               state_reg;
    back_state_t               state_next;
    logic [SAMPLE_BITS-1:0]    avg_reg;
    logic [SAMPLE_BITS-1:0]    avg_next;
    logic                      inv_reg;
    logic                      inv_next;
    logic [VALUE_BITS-1:0]     val_reg;
    logic [VALUE_BITS-1:0]     val_next;
    logic [ADC_BITS-1:0]       rem_reg;
    logic [ADC_BITS-1:0]       rem_next;
    logic [VALUE_BITS-1:0]     num_low_reg;
    logic [VALUE_BITS-1:0]     num_low_next;
    logic [DIV_CNT_BITS-1:0]   bit_cnt_reg;
    logic [DIV_CNT_BITS-1:0]   bit_cnt_next;
    logic [SECONDS_BITS-1:0]   seconds_reg;
    logic [SECONDS_BITS-1:0]   seconds_next;
    logic                      has_sent_reg;
    logic                      has_sent_next;
    logic [SAMPLE_BITS-1:0]    kept_avg_reg;
    logic [SAMPLE_BITS-1:0]    kept_avg_next;
    logic                      kept_inv_reg;
    logic                      kept_inv_next;
    logic [VALUE_BITS-1:0]     sent_val_reg;
    logic [VALUE_BITS-1:0]     sent_val_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    result_t                   out_reg;
    result_t                   out_next;

    logic [ADC_BITS-1:0]       span;
    logic [ADC_BITS-1:0]       diff;
    logic [PROD_BITS-1:0]      prod;
    logic                      scale_zero;
    logic [ADC_BITS:0]         rem_shift;
    logic                      q_bit;
    logic [SAMPLE_BITS-1:0]    avg_delta;
    logic                      missed;
    logic                      early;
    logic                      keep;
    logic [STATUS_BITS-1:0]    status;
    logic                      out_free;
    logic                      take_group;

    always_comb
    begin
        span       = cfg.adc_max - cfg.adc_min;
        diff       = ADC_BITS'(q_job.avg) - cfg.adc_min;
        prod       = {diff, VALUE_BITS'(0)} - PROD_BITS'({diff, 1'b0});
        scale_zero = (cfg.adc_max <= cfg.adc_min) || (ADC_BITS'(q_job.avg) < cfg.adc_min);
        take_group = q_valid && !q_job.is_tick;

        rem_shift = {rem_reg, num_low_reg[VALUE_BITS-1]};
        q_bit     = (rem_shift >= {1'b0, span});

        avg_delta = (avg_reg >= kept_avg_reg) ? avg_reg - kept_avg_reg
                                              : kept_avg_reg - avg_reg;
        if (inv_reg != kept_inv_reg)
        begin
            missed = 1'b0;
        end
        else if (inv_reg)
        begin
            missed = (cfg.deadband != '0);
        end
        else
        begin
            missed = (DEADBAND_BITS'(avg_delta) < cfg.deadband);
        end

        early = (seconds_reg < cfg.send_interval);
        keep  = !has_sent_reg || (!early && !missed);
        if (!has_sent_reg)
        begin
            status = STATUS_SENT;
        end
        else if (early)
        begin
            status = STATUS_INTERVAL;
        end
        else if (missed)
        begin
            status = STATUS_DEADBAND;
        end
        else if (val_reg == sent_val_reg)
        begin
            status = STATUS_UNCHANGED;
        end
        else
        begin
            status = STATUS_SENT;
        end

        out_free = !out_valid_reg || pop;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take_group)
                begin
                    state_next = (q_job.inv || scale_zero) ? ST_DECIDE : ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (bit_cnt_reg == '0)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop          = 1'b0;
        avg_next       = avg_reg;
        inv_next       = inv_reg;
        val_next       = val_reg;
        rem_next       = rem_reg;
        num_low_next   = num_low_reg;
        bit_cnt_next   = bit_cnt_reg;
        seconds_next   = seconds_reg;
        has_sent_next  = has_sent_reg;
        kept_avg_next  = kept_avg_reg;
        kept_inv_next  = kept_inv_reg;
        sent_val_next  = sent_val_reg;
        out_valid_next = out_valid_reg && !pop;
        out_next       = out_reg;

        case (state_reg)
            ST_IDLE:
            begin
                q_pop = q_valid;
                if (q_valid && q_job.is_tick)
                begin
                    if (seconds_reg != '1)
                    begin
                        seconds_next = seconds_reg + SECONDS_BITS'(1);
                    end
                end
                else if (take_group)
                begin
                    avg_next     = q_job.avg;
                    inv_next     = q_job.inv;
                    rem_next     = prod[PROD_BITS-1:VALUE_BITS];
                    num_low_next = prod[VALUE_BITS-1:0];
                    bit_cnt_next = DIV_CNT_BITS'(VALUE_BITS - 1);
                    if (q_job.inv)
                    begin
                        val_next = VALUE_INVALID;
                    end
                    else
                    begin
                        val_next = '0;
                    end
                end
            end
            ST_DIVIDE:
            begin
                rem_next     = q_bit ? ADC_BITS'(rem_shift - {1'b0, span})
                                     : rem_shift[ADC_BITS-1:0];
                val_next     = {val_reg[VALUE_BITS-2:0], q_bit};
                num_low_next = {num_low_reg[VALUE_BITS-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - DIV_CNT_BITS'(1);
            end
            ST_DECIDE:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next.status      = status;
                    out_next.out_value   = val_reg;
                    out_next.raw_average = AVG_BITS'(avg_reg);
                    out_next.invalid     = inv_reg;
                    if (keep)
                    begin
                        kept_avg_next = avg_reg;
                        kept_inv_next = inv_reg;
                    end
                    if (status == STATUS_SENT)
                    begin
                        sent_val_next = val_reg;
                        seconds_next  = '0;
                        has_sent_next = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase

        out_valid = out_valid_reg;
        result    = out_reg;
    end

    always_ff @(posedge clk)
    begin
        avg_reg     <= avg_next;
        inv_reg     <= inv_next;
        val_reg     <= val_next;
        rem_reg     <= rem_next;
        num_low_reg <= num_low_next;
        bit_cnt_reg <= bit_cnt_next;
        out_reg     <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seconds_reg   <= '0;
            has_sent_reg  <= 1'b0;
            kept_avg_reg  <= '0;
            kept_inv_reg  <= 1'b0;
            sent_val_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seconds_reg   <= seconds_next;
            has_sent_reg  <= has_sent_next;
            kept_avg_reg  <= kept_avg_next;
            kept_inv_reg  <= kept_inv_next;
            sent_val_reg  <= sent_val_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[src/loop_current_average_report_top.sv]
// Top level of the loop current average and report block.
//
//   Channel   Handshake                Payload
//   input     push / full              operation, sample
//   result    empty / pop              status, out_value, raw_average, invalid
//   config    cfg_valid / cfg_ready    cfg_index, cfg_data
//
// The front end takes one item per cycle while the job queue is not full. The back end
// counts a tick while idle; a group end is loaded, gets eight quotient bits from the scaling
// divide, then is decided when the result is free; invalid or zero-span groups skip the divide.
// A four-entry job queue lets the front end keep accepting while the back end divides or
// waits for the result to be popped; full rises only when that queue fills.
// Reset clears all control state and loads the register defaults; no clearing pass is needed.
module loop_current_average_report_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic                                 operation,
    input  logic [lcar_pkg::SAMPLE_BITS-1:0]     sample,
    output logic                                 empty,
    input  logic                                 pop,
    output logic [lcar_pkg::STATUS_BITS-1:0]     status,
    output logic [lcar_pkg::VALUE_BITS-1:0]      out_value,
    output logic [lcar_pkg::AVG_BITS-1:0]        raw_average,
    output logic                                 invalid,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lcar_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [lcar_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import lcar_pkg::*;

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    logic    enq_valid;
    job_t    enq_job;
    logic    q_full;
    logic    q_valid;
    job_t    q_job;
    logic    q_pop;
    logic    out_valid;
    result_t result;

    always_comb
    begin
        cfg_ready = 1'b1;
        cfg_next  = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ADC_MIN:       cfg_next.adc_min       = cfg_data[ADC_BITS-1:0];
                CFG_ADC_MAX:       cfg_next.adc_max       = cfg_data[ADC_BITS-1:0];
                CFG_DEADBAND:      cfg_next.deadband      = cfg_data[DEADBAND_BITS-1:0];
                CFG_SEND_INTERVAL: cfg_next.send_interval = cfg_data[SECONDS_BITS-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.adc_min       <= ADC_MIN_RESET;
            cfg_reg.adc_max       <= ADC_MAX_RESET;
            cfg_reg.deadband      <= DEADBAND_RESET;
            cfg_reg.send_interval <= SEND_INTERVAL_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lcar_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .push      (push),
        .operation (operation),
        .sample    (sample),
        .q_full    (q_full),
        .enq_valid (enq_valid),
        .enq_job   (enq_job)
    );

    lcar_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (enq_valid),
        .wr_job   (enq_job),
        .full     (q_full),
        .rd_pop   (q_pop),
        .rd_valid (q_valid),
        .rd_job   (q_job)
    );

    lcar_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_job     (q_job),
        .q_pop     (q_pop),
        .pop       (pop),
        .out_valid (out_valid),
        .result    (result)
    );

    assign full        = q_full;
    assign empty       = !out_valid;
    assign status      = result.status;
    assign out_value   = result.out_value;
    assign raw_average = result.raw_average;
    assign invalid     = result.invalid;

endmodule
